/* design/cbm_pkg.sv */
// shared types and constants of the cartridge bank mapper register block
package cbm_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_PRG   = 3'd1;
  localparam logic [2:0] KIND_CHR   = 3'd2;
  localparam logic [2:0] KIND_NAME  = 3'd3;
  localparam logic [2:0] KIND_SAVE  = 3'd4;

  localparam logic [1:0] PRG_MODE_32K = 2'd0;
  localparam logic [1:0] PRG_MODE_16K = 2'd1;
  localparam logic [1:0] PRG_MODE_MIX = 2'd2;
  localparam logic [1:0] PRG_MODE_8K  = 2'd3;
  localparam logic [1:0] CHR_MODE_1K  = 2'd3;

  localparam logic [14:0] ADDR_PRG_MODE  = 15'h5100;
  localparam logic [14:0] ADDR_CHR_MODE  = 15'h5101;
  localparam logic [14:0] ADDR_KEY_A     = 15'h5103;
  localparam logic [14:0] ADDR_KEY_B     = 15'h5104;
  localparam logic [14:0] ADDR_MIRROR    = 15'h5105;
  localparam logic [14:0] ADDR_SAVE_PAGE = 15'h5113;
  localparam logic [14:0] ADDR_PRG_BANK0 = 15'h5114;
  localparam logic [14:0] ADDR_PRG_BANK3 = 15'h5117;
  localparam logic [14:0] ADDR_CHR_FIRST = 15'h5120;
  localparam logic [14:0] ADDR_CHR_LAST  = 15'h512B;
  localparam logic [14:0] ADDR_IRQ_LINE  = 15'h5203;
  localparam logic [14:0] ADDR_IRQ_CTRL  = 15'h5204;
  localparam logic [14:0] ADDR_MUL_A     = 15'h5205;
  localparam logic [14:0] ADDR_MUL_B     = 15'h5206;

  localparam logic [1:0] KEY_A_UNLOCK = 2'd2;
  localparam logic [1:0] KEY_B_UNLOCK = 2'd1;

  localparam logic [7:0] STAT_FRAME = 8'h40;
  localparam logic [7:0] STAT_PEND  = 8'h80;
  localparam logic [8:0] LINE_FRAME_START = 9'd0;
  localparam logic [8:0] LINE_FRAME_END   = 9'd239;
  localparam logic [7:0] READ_UNMAPPED    = 8'hFF;

  localparam logic CFG_CHR_IS_RAM = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] reg_addr;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
  } cbm_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [7:0] bank;
    logic       ram;
  } cbm_entry_t;

  typedef struct packed {
    logic [7:0]            read_data;
    logic                  irq_request;
    logic                  prg_writable;
    logic [1:0]            last_idx;
    cbm_entry_t [3:0]      entries;
  } cbm_batch_t;

endpackage

/* design/cbm_if.sv */
// valid/ready channel interfaces for requests and results
interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [14:0] reg_addr;
  logic [7:0]  write_data;
  logic [8:0]  scanline;

  modport source (output valid, req_type, reg_addr, write_data, scanline, input ready);
  modport sink (input valid, req_type, reg_addr, write_data, scanline, output ready);
endinterface

interface cbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic       prg_writable;
  logic [2:0] update_kind;
  logic [2:0] slot_index;
  logic [7:0] bank_number;
  logic       bank_is_ram;
  logic       last_result;

  modport source (output valid, read_data, irq_request, prg_writable, update_kind,
                  slot_index, bank_number, bank_is_ram, last_result, input ready);
  modport sink (input valid, read_data, irq_request, prg_writable, update_kind,
                slot_index, bank_number, bank_is_ram, last_result, output ready);
endinterface

/* design/cbm_core.sv */
// mapper register state and single-pass decode of one transaction into a result batch
module cbm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  cbm_pkg::cbm_item_t item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  output cbm_pkg::cbm_batch_t batch
);

  logic [1:0]  prg_mode_r, prg_mode_nxt;
  logic [1:0]  chr_mode_r, chr_mode_nxt;
  logic [7:0]  irq_line_r, irq_line_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic [7:0]  irq_stat_r, irq_stat_nxt;
  logic [1:0]  key_a_r, key_a_nxt;
  logic [1:0]  key_b_r, key_b_nxt;
  logic        unlocked_r, unlocked_nxt;
  logic [7:0]  fac_a_r, fac_a_nxt;
  logic [7:0]  fac_b_r, fac_b_nxt;
  logic [15:0] product_r, product_nxt;
  logic        chr_ram_r;

  logic [7:0]  rd;
  logic [2:0]  cnt;
  logic [2:0]  pslot;
  logic [2:0]  pn;
  logic        pram;
  logic [6:0]  pbank;
  logic [3:0]  creg;
  logic [2:0]  cslot;
  cbm_pkg::cbm_entry_t [3:0] ent;

  always_comb begin
    prg_mode_nxt = prg_mode_r;
    chr_mode_nxt = chr_mode_r;
    irq_line_nxt = irq_line_r;
    irq_en_nxt   = irq_en_r;
    irq_stat_nxt = irq_stat_r;
    key_a_nxt    = key_a_r;
    key_b_nxt    = key_b_r;
    unlocked_nxt = unlocked_r;
    fac_a_nxt    = fac_a_r;
    fac_b_nxt    = fac_b_r;
    product_nxt  = product_r;
    rd    = 8'd0;
    cnt   = 3'd0;
    ent   = '0;
    pn    = 3'd0;
    pslot = 3'd0;
    pram  = ~item.write_data[7];
    pbank = pram ? {4'd0, item.write_data[2:0]} : item.write_data[6:0];
    creg  = item.reg_addr[3:0];
    cslot = creg[3] ? {1'b1, creg[1:0]} : creg[2:0];

    unique case (item.req_type)
      cbm_pkg::REQ_WRITE: begin
        if (item.reg_addr >= cbm_pkg::ADDR_PRG_BANK0 &&
            item.reg_addr <= cbm_pkg::ADDR_PRG_BANK3) begin
          unique case (item.reg_addr[1:0])
            2'd0: begin
              if (prg_mode_r == cbm_pkg::PRG_MODE_8K) begin
                pn = 3'd1; pslot = 3'd0;
              end
            end
            2'd1: begin
              if (prg_mode_r == cbm_pkg::PRG_MODE_16K ||
                  prg_mode_r == cbm_pkg::PRG_MODE_MIX) begin
                pn = 3'd2; pslot = 3'd0;
              end else if (prg_mode_r == cbm_pkg::PRG_MODE_8K) begin
                pn = 3'd1; pslot = 3'd1;
              end
            end
            2'd2: begin
              if (prg_mode_r == cbm_pkg::PRG_MODE_MIX || prg_mode_r == cbm_pkg::PRG_MODE_8K) begin
                pn = 3'd1; pslot = 3'd2;
              end
            end
            default: begin
              priority if (prg_mode_r == cbm_pkg::PRG_MODE_32K) begin
                pn = 3'd4; pslot = 3'd0;
              end else if (prg_mode_r == cbm_pkg::PRG_MODE_16K) begin
                pn = 3'd2; pslot = 3'd2;
              end else begin
                pn = 3'd1; pslot = 3'd3;
              end
            end
          endcase
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < pn) begin
              ent[i].kind = cbm_pkg::KIND_PRG;
              ent[i].slot = pslot + 3'(i);
              ent[i].bank = {1'b0, pbank} + 8'(i);
              ent[i].ram  = pram;
            end
          end
          cnt = pn;
        end else if (item.reg_addr >= cbm_pkg::ADDR_CHR_FIRST &&
                     item.reg_addr <= cbm_pkg::ADDR_CHR_LAST) begin
          if (chr_mode_r == cbm_pkg::CHR_MODE_1K) begin
            ent[0].kind = cbm_pkg::KIND_CHR;
            ent[0].slot = cslot;
            ent[0].bank = chr_ram_r ? {5'd0, item.write_data[2:0]} : item.write_data;
            ent[0].ram  = chr_ram_r;
            cnt = 3'd1;
          end
        end else begin
          unique case (item.reg_addr)
            cbm_pkg::ADDR_PRG_MODE: prg_mode_nxt = item.write_data[1:0];
            cbm_pkg::ADDR_CHR_MODE: chr_mode_nxt = item.write_data[1:0];
            cbm_pkg::ADDR_KEY_A:    key_a_nxt    = item.write_data[1:0];
            cbm_pkg::ADDR_KEY_B:    key_b_nxt    = item.write_data[1:0];
            cbm_pkg::ADDR_MIRROR: begin
              for (int i = 0; i < 4; i++) begin
                ent[i].kind = cbm_pkg::KIND_NAME;
                ent[i].slot = 3'(i);
                ent[i].bank = {6'd0, item.write_data[2*i +: 2]};
                ent[i].ram  = 1'b0;
              end
              cnt = 3'd4;
            end
            cbm_pkg::ADDR_SAVE_PAGE: begin
              ent[0].kind = cbm_pkg::KIND_SAVE;
              ent[0].slot = 3'd0;
              ent[0].bank = {5'd0, item.write_data[2:0]};
              ent[0].ram  = 1'b1;
              cnt = 3'd1;
            end
            cbm_pkg::ADDR_IRQ_LINE: irq_line_nxt = item.write_data;
            cbm_pkg::ADDR_IRQ_CTRL: irq_en_nxt   = item.write_data[7];
            cbm_pkg::ADDR_MUL_A: begin
              fac_a_nxt   = item.write_data;
              product_nxt = 16'(item.write_data) * 16'(fac_b_r);
            end
            cbm_pkg::ADDR_MUL_B: begin
              fac_b_nxt   = item.write_data;
              product_nxt = 16'(fac_a_r) * 16'(item.write_data);
            end
            default: ;
          endcase
        end
      end
      cbm_pkg::REQ_READ: begin
        unique case (item.reg_addr)
          cbm_pkg::ADDR_IRQ_CTRL: begin
            rd = irq_stat_r;
            irq_stat_nxt = irq_stat_r & ~cbm_pkg::STAT_PEND;
          end
          cbm_pkg::ADDR_MUL_A: rd = product_r[7:0];
          cbm_pkg::ADDR_MUL_B: rd = product_r[15:8];
          default:             rd = cbm_pkg::READ_UNMAPPED;
        endcase
      end
      cbm_pkg::REQ_TICK: begin
        if (item.scanline == cbm_pkg::LINE_FRAME_START) begin
          irq_stat_nxt = cbm_pkg::STAT_FRAME;
        end
        if (item.scanline == cbm_pkg::LINE_FRAME_END) begin
          irq_stat_nxt = irq_stat_nxt & ~cbm_pkg::STAT_FRAME;
        end
        if (irq_line_r != 8'd0 && item.scanline == {1'b0, irq_line_r}) begin
          irq_stat_nxt = irq_stat_nxt | cbm_pkg::STAT_PEND;
        end
      end
      default: ;
    endcase

    if (cnt == 3'd0) begin
      cnt = 3'd1;
    end
    // lock state only changes on a key write
    if (item.req_type == cbm_pkg::REQ_WRITE &&
        (item.reg_addr == cbm_pkg::ADDR_KEY_A || item.reg_addr == cbm_pkg::ADDR_KEY_B)) begin
      unlocked_nxt = (key_a_nxt == cbm_pkg::KEY_A_UNLOCK) &&
                     (key_b_nxt == cbm_pkg::KEY_B_UNLOCK);
    end

    batch.read_data    = rd;
    batch.irq_request  = irq_en_nxt & irq_stat_nxt[7];
    batch.prg_writable = unlocked_nxt;
    batch.last_idx     = 2'(cnt - 3'd1);
    batch.entries      = ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mode_r <= 2'd0;
      chr_mode_r <= 2'd0;
      irq_line_r <= 8'd0;
      irq_en_r   <= 1'b0;
      irq_stat_r <= 8'd0;
      key_a_r    <= 2'd0;
      key_b_r    <= 2'd0;
      unlocked_r <= 1'b1;
      fac_a_r    <= 8'd0;
      fac_b_r    <= 8'd0;
      product_r  <= 16'd0;
    end else if (fire) begin
      prg_mode_r <= prg_mode_nxt;
      chr_mode_r <= chr_mode_nxt;
      irq_line_r <= irq_line_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_stat_r <= irq_stat_nxt;
      key_a_r    <= key_a_nxt;
      key_b_r    <= key_b_nxt;
      unlocked_r <= unlocked_nxt;
      fac_a_r    <= fac_a_nxt;
      fac_b_r    <= fac_b_nxt;
      product_r  <= product_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_ram_r <= 1'b0;
    end else if (cfg_we && cfg_index == cbm_pkg::CFG_CHR_IS_RAM) begin
      chr_ram_r <= cfg_wdata[0];
    end
  end

endmodule

/* design/cbm_drain.sv */
// result batch register and one-per-cycle result serializer, held while out_ch.ready is low
module cbm_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  cbm_pkg::cbm_batch_t batch_in,
  output logic                free,
  cbm_out_if.source           out_ch
);

  logic                bat_valid_r;
  cbm_pkg::cbm_batch_t bat_r;
  logic [1:0]          idx_r;
  logic                last;
  logic                done;

  assign last = (idx_r == bat_r.last_idx);
  assign done = out_ch.valid && out_ch.ready && last;
  assign free = !bat_valid_r || done;

  assign out_ch.valid        = bat_valid_r;
  assign out_ch.read_data    = bat_r.read_data;
  assign out_ch.irq_request  = bat_r.irq_request;
  assign out_ch.prg_writable = bat_r.prg_writable;
  assign out_ch.update_kind  = bat_r.entries[idx_r].kind;
  assign out_ch.slot_index   = bat_r.entries[idx_r].slot;
  assign out_ch.bank_number  = bat_r.entries[idx_r].bank;
  assign out_ch.bank_is_ram  = bat_r.entries[idx_r].ram;
  assign out_ch.last_result  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bat_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        bat_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (done) begin
        bat_valid_r <= 1'b0;
        idx_r       <= 2'd0;
      end else if (out_ch.valid && out_ch.ready) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bat_r <= batch_in;
    end
  end

endmodule

/* design/cartridge_bank_mapper_registers_unit.sv */
// top level: input staging register, mapper decode core and result serializer
// path: input staging register, then core decode into the batch register, from which
//   the first result is offered; throughput: one transaction per cycle when each yields
//   one result and out_ch.ready is high; a transaction yielding 1 to 4 results holds the
//   serializer until its last is taken, issuing one result per cycle unless stalled
// reset: synchronous active-low rst_n returns all mapper state to its reset values
//   (program writes unlocked) and empties both pipeline stages
module cartridge_bank_mapper_registers_unit (
  input  logic       clk,
  input  logic       rst_n,
  cbm_in_if.sink     in_ch,
  cbm_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic                in_valid_r;
  cbm_pkg::cbm_item_t  in_item_r;
  logic                free;
  logic                move;
  cbm_pkg::cbm_batch_t batch;

  assign move        = in_valid_r && free;
  assign in_ch.ready = !in_valid_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.req_type   <= in_ch.req_type;
      in_item_r.reg_addr   <= in_ch.reg_addr;
      in_item_r.write_data <= in_ch.write_data;
      in_item_r.scanline   <= in_ch.scanline;
    end
  end

  cbm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (move),
    .item      (in_item_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .batch     (batch)
  );

  cbm_drain u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (move),
    .batch_in (batch),
    .free     (free),
    .out_ch   (out_ch)
  );

endmodule

/* design/cbm_checker.sv */
// port-level checker for the mapper register block, bound to the top level
module cbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [2:0] out_update_kind,
  input logic [2:0] out_slot_index,
  input logic [7:0] out_bank_number,
  input logic       out_bank_is_ram,
  input logic       out_last_result
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_update_kind) &&
      $stable(out_slot_index) && $stable(out_bank_number) && $stable(out_read_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_none_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_update_kind == cbm_pkg::KIND_NONE |-> out_last_result)
    else $error("empty update is not the only result of its transaction");

  a_name_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_update_kind == cbm_pkg::KIND_NAME |->
      !out_bank_is_ram && out_bank_number[7:2] == 6'd0)
    else $error("nametable update out of range");

endmodule

bind cartridge_bank_mapper_registers_unit cbm_checker u_cbm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_read_data   (out_ch.read_data),
  .out_update_kind (out_ch.update_kind),
  .out_slot_index  (out_ch.slot_index),
  .out_bank_number (out_ch.bank_number),
  .out_bank_is_ram (out_ch.bank_is_ram),
  .out_last_result (out_ch.last_result)
);
